### hw/rtl/ccbd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccbd_pkg
// shared types and constants for the console bus decoder with pad ports
// ----------------------------------------------------------------------------
package ccbd_pkg;

    localparam int RAM_BYTES_DEF = 2048;
    localparam int RAM_SPAN      = 8192;

    typedef enum logic [1:0] {
        MODE_READ  = 2'd0,
        MODE_WRITE = 2'd1,
        MODE_PAD   = 2'd2,
        MODE_NONE  = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        TGT_INTERNAL = 3'd0,
        TGT_PICTURE  = 3'd1,
        TGT_AUDIO    = 3'd2,
        TGT_CART     = 3'd3,
        TGT_DMA      = 3'd4,
        TGT_NONE     = 3'd5
    } t_target;

    localparam logic [15:0] ADDR_PICTURE = 16'h2000;
    localparam logic [15:0] ADDR_IO      = 16'h4000;
    localparam logic [15:0] ADDR_DMA     = 16'h4014;
    localparam logic [15:0] ADDR_APU_ST  = 16'h4015;
    localparam logic [15:0] ADDR_PAD0    = 16'h4016;
    localparam logic [15:0] ADDR_PAD1    = 16'h4017;
    localparam logic [15:0] ADDR_IO_END  = 16'h4018;
    localparam logic [15:0] ADDR_CART    = 16'h4020;
    localparam logic [7:0]  PAD_OPEN_BUS = 8'h40;

    typedef struct packed {
        t_target     target;
        logic [15:0] fwd_address;
        logic [7:0]  fwd_data;
        logic        fwd_write;
        logic        ram_rd;
        logic        ram_wr;
        logic        pad_rd;
        logic        pad_sel;
        logic        strobe_wr;
        logic        btn_wr;
        logic        btn_pad;
    } t_dec;

endpackage

### hw/rtl/console_cpu_bus_decoder_pads_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// console_cpu_bus_decoder_pads_unit
// cpu bus decoder with internal work ram and two pad shift ports
// ----------------------------------------------------------------------------
// Takes one word per cycle while o_stall is low (bus read, bus write, pad
// button update or none) and returns one result word per input word. The
// first stage decodes the address and forms the mirrored ram index; the
// second does the single ram access and the pad register update and
// registers the result. After reset the work ram is swept to zero, during
// which o_stall stays high.
module console_cpu_bus_decoder_pads_unit #(
    parameter int RAM_BYTES = ccbd_pkg::RAM_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_mode,
    input  logic [15:0] i_address,
    input  logic [7:0]  i_data_in,
    input  logic [1:0]  i_pad,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_target,
    output logic [7:0]  o_read_data,
    output logic [15:0] o_fwd_address,
    output logic [7:0]  o_fwd_data,
    output logic        o_fwd_write
);
    import ccbd_pkg::*;

    localparam int AW = $clog2(RAM_BYTES);

    t_dec          w_dec;
    logic [AW-1:0] w_idx;
    logic          w_accept;
    logic          w_adv;
    logic          w_busy;
    logic          w_pad_bit;
    logic [7:0]    w_ram_q;

    logic          r1_v;
    t_dec          r1_dec;
    logic [AW-1:0] r1_idx;
    logic [7:0]    r1_data;

    logic          r2_v;
    t_target       r2_target;
    logic          r2_ram_sel;
    logic [7:0]    r2_rd;
    logic [15:0]   r2_fa;
    logic [7:0]    r2_fd;
    logic          r2_fw;

    ccbd_decode #(
        .RAM_BYTES (RAM_BYTES)
    ) u_decode (
        .i_mode    (i_mode),
        .i_address (i_address),
        .i_data_in (i_data_in),
        .i_pad     (i_pad),
        .o_dec     (w_dec),
        .o_idx     (w_idx)
    );

    assign w_adv    = r1_v && (!r2_v || !i_stall);
    assign o_stall  = w_busy || (r1_v && !w_adv);
    assign w_accept = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else begin
            r1_v <= w_accept || (r1_v && !w_adv);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r1_dec  <= w_dec;
            r1_idx  <= w_idx;
            r1_data <= i_data_in;
        end
    end

    ccbd_ram #(
        .RAM_BYTES (RAM_BYTES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_rd    (r1_dec.ram_rd),
        .i_wr    (r1_dec.ram_wr),
        .i_idx   (r1_idx),
        .i_wdata (r1_data),
        .o_rdata (w_ram_q),
        .o_busy  (w_busy)
    );

    ccbd_pads u_pads (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_dec   (r1_dec),
        .i_data  (r1_data),
        .o_bit   (w_pad_bit)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (w_adv) begin
            r2_v <= 1'b1;
        end else if (!i_stall) begin
            r2_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r2_target  <= r1_dec.target;
            r2_ram_sel <= r1_dec.ram_rd;
            r2_rd      <= r1_dec.pad_rd ? (PAD_OPEN_BUS | {7'd0, w_pad_bit}) : 8'h00;
            r2_fa      <= r1_dec.fwd_address;
            r2_fd      <= r1_dec.fwd_data;
            r2_fw      <= r1_dec.fwd_write;
        end
    end

    assign o_valid       = r2_v;
    assign o_target      = r2_target;
    assign o_read_data   = r2_ram_sel ? w_ram_q : r2_rd;
    assign o_fwd_address = r2_fa;
    assign o_fwd_data    = r2_fd;
    assign o_fwd_write   = r2_fw;

endmodule

### hw/rtl/ccbd_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccbd_decode
// address and mode decode, ram mirror index
// ----------------------------------------------------------------------------
module ccbd_decode #(
    parameter int RAM_BYTES = ccbd_pkg::RAM_BYTES_DEF
) (
    input  logic [1:0]                     i_mode,
    input  logic [15:0]                    i_address,
    input  logic [7:0]                     i_data_in,
    input  logic [1:0]                     i_pad,
    output ccbd_pkg::t_dec                 o_dec,
    output logic [$clog2(RAM_BYTES)-1:0]   o_idx
);
    import ccbd_pkg::*;

    localparam int AW   = $clog2(RAM_BYTES);
    localparam int QMAX = (RAM_SPAN - 1) / RAM_BYTES;

    logic [12:0] w_low;
    logic [12:0] w_rem;

    assign w_low = i_address[12:0];

    // mirror: subtract the largest multiple of the ram size
    always_comb begin
        w_rem = w_low;
        for (int k = 1; k <= QMAX; k++) begin
            if ({1'b0, w_low} >= 14'(k * RAM_BYTES)) begin
                w_rem = 13'({1'b0, w_low} - 14'(k * RAM_BYTES));
            end
        end
    end

    assign o_idx = w_rem[AW-1:0];

    always_comb begin
        o_dec = '0;
        o_dec.target = TGT_NONE;
        unique case (t_mode'(i_mode))
            MODE_READ: begin
                if (i_address < ADDR_PICTURE) begin
                    o_dec.target = TGT_INTERNAL;
                    o_dec.ram_rd = 1'b1;
                end else if (i_address < ADDR_IO) begin
                    o_dec.target      = TGT_PICTURE;
                    o_dec.fwd_address = i_address;
                end else if (i_address == ADDR_APU_ST) begin
                    o_dec.target      = TGT_AUDIO;
                    o_dec.fwd_address = i_address;
                end else if (i_address == ADDR_PAD0 || i_address == ADDR_PAD1) begin
                    o_dec.target  = TGT_INTERNAL;
                    o_dec.pad_rd  = 1'b1;
                    o_dec.pad_sel = i_address[0];
                end else if (i_address < ADDR_CART) begin
                    o_dec.target = TGT_INTERNAL;
                end else begin
                    o_dec.target      = TGT_CART;
                    o_dec.fwd_address = i_address;
                end
            end
            MODE_WRITE: begin
                if (i_address < ADDR_PICTURE) begin
                    o_dec.target = TGT_INTERNAL;
                    o_dec.ram_wr = 1'b1;
                end else if (i_address < ADDR_IO) begin
                    o_dec.target      = TGT_PICTURE;
                    o_dec.fwd_address = i_address;
                    o_dec.fwd_data    = i_data_in;
                    o_dec.fwd_write   = 1'b1;
                end else if (i_address == ADDR_DMA) begin
                    o_dec.target      = TGT_DMA;
                    o_dec.fwd_address = i_address;
                    o_dec.fwd_data    = i_data_in;
                    o_dec.fwd_write   = 1'b1;
                end else if (i_address == ADDR_PAD0) begin
                    o_dec.target    = TGT_INTERNAL;
                    o_dec.strobe_wr = 1'b1;
                end else if (i_address < ADDR_IO_END) begin
                    o_dec.target      = TGT_AUDIO;
                    o_dec.fwd_address = i_address;
                    o_dec.fwd_data    = i_data_in;
                    o_dec.fwd_write   = 1'b1;
                end else if (i_address < ADDR_CART) begin
                    o_dec.target = TGT_NONE;
                end else begin
                    o_dec.target      = TGT_CART;
                    o_dec.fwd_address = i_address;
                    o_dec.fwd_data    = i_data_in;
                    o_dec.fwd_write   = 1'b1;
                end
            end
            MODE_PAD: begin
                o_dec.btn_wr  = ~i_pad[1];
                o_dec.btn_pad = i_pad[0];
            end
            MODE_NONE: begin
                o_dec.target = TGT_NONE;
            end
            default: begin
                o_dec.target = TGT_NONE;
            end
        endcase
    end

endmodule

### hw/rtl/ccbd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccbd_ram
// work ram with registered read and a zero fill sweep after reset
// ----------------------------------------------------------------------------
module ccbd_ram #(
    parameter int RAM_BYTES = ccbd_pkg::RAM_BYTES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_rd,
    input  logic                           i_wr,
    input  logic [$clog2(RAM_BYTES)-1:0]   i_idx,
    input  logic [7:0]                     i_wdata,
    output logic [7:0]                     o_rdata,
    output logic                           o_busy
);
    import ccbd_pkg::*;

    localparam int AW = $clog2(RAM_BYTES);

    logic [7:0]    r_mem [RAM_BYTES];
    logic [AW-1:0] r_clr_idx;
    logic          r_busy;
    logic [7:0]    r_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b1;
            r_clr_idx <= '0;
        end else if (r_busy) begin
            r_clr_idx <= r_clr_idx + 1'b1;
            if (r_clr_idx == AW'(RAM_BYTES - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_mem[r_clr_idx] <= 8'h00;
        end else if (i_en && i_wr) begin
            r_mem[i_idx] <= i_wdata;
        end
        if (i_en && i_rd) begin
            r_rdata <= r_mem[i_idx];
        end
    end

    assign o_rdata = r_rdata;
    assign o_busy  = r_busy;

endmodule

### hw/rtl/ccbd_pads.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccbd_pads
// strobe latch, button states and shift registers for two pads
// ----------------------------------------------------------------------------
module ccbd_pads (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  ccbd_pkg::t_dec i_dec,
    input  logic [7:0]     i_data,
    output logic           o_bit
);
    import ccbd_pkg::*;

    logic       r_strobe;
    logic [7:0] r_state [2];
    logic [7:0] r_shift [2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe   <= 1'b0;
            r_state[0] <= '0;
            r_state[1] <= '0;
            r_shift[0] <= '0;
            r_shift[1] <= '0;
        end else if (i_en) begin
            if (i_dec.pad_rd) begin
                r_shift[i_dec.pad_sel] <= {1'b0, r_shift[i_dec.pad_sel][7:1]};
            end
            if (i_dec.strobe_wr) begin
                if (i_data[0]) begin
                    r_strobe <= 1'b1;
                end else if (r_strobe) begin
                    r_strobe   <= 1'b0;
                    r_shift[0] <= r_state[0];
                    r_shift[1] <= r_state[1];
                end
            end
            if (i_dec.btn_wr) begin
                r_state[i_dec.btn_pad] <= i_data;
                if (r_strobe) begin
                    r_shift[i_dec.btn_pad] <= i_data;
                end
            end
        end
    end

    assign o_bit = r_shift[i_dec.pad_sel][0];

endmodule

### dv/tb_console_cpu_bus_decoder_pads_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_console_cpu_bus_decoder_pads_unit
// bus decode, work ram and pad shift port checks for the console bus decoder
// ----------------------------------------------------------------------------
// A directed table covers the address map edges, every bus mode, the ignored
// words and the strobe and latch sequence of the pads. A random part follows
// that mixes strobe, button update and serial read sequences, ram traffic on
// a narrow address set, io, picture and cartridge accesses and random words.
// Result words are compared in order with the table or a bench decoder model;
// both sides idle and stall at random outside a stretch run without gaps.
module tb_console_cpu_bus_decoder_pads_unit;
    import ccbd_pkg::*;

    localparam int IDLE_PCT    = 19;
    localparam int RAND_WORDS  = 1900;
    localparam int STALL_LIMIT = 20000;

    typedef struct packed {
        t_target     target;
        logic [7:0]  read_data;
        logic [15:0] fwd_address;
        logic [7:0]  fwd_data;
        logic        fwd_write;
    } t_bus_res;

    typedef struct packed {
        t_mode       mode;
        logic [15:0] addr;
        logic [7:0]  data;
        logic [1:0]  pad;
        logic        typed;
        t_bus_res    res;
    } t_stim_row;

    localparam t_bus_res NO_RES = '0;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [1:0]  i_mode;
    logic [15:0] i_address;
    logic [7:0]  i_data_in;
    logic [1:0]  i_pad;
    logic        o_valid;
    logic        i_stall;
    logic [2:0]  o_target;
    logic [7:0]  o_read_data;
    logic [15:0] o_fwd_address;
    logic [7:0]  o_fwd_data;
    logic        o_fwd_write;

    logic [7:0] work_mem [RAM_BYTES_DEF];
    logic       strobe_on;
    logic [7:0] btn_latch [2];
    logic [7:0] btn_shreg [2];

    t_bus_res  pending_res [$];
    t_stim_row dir_rows [25];
    int        err_cnt;
    int        words_sent;
    bit        no_gaps;

    console_cpu_bus_decoder_pads_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_mode        (i_mode),
        .i_address     (i_address),
        .i_data_in     (i_data_in),
        .i_pad         (i_pad),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_target      (o_target),
        .o_read_data   (o_read_data),
        .o_fwd_address (o_fwd_address),
        .o_fwd_data    (o_fwd_data),
        .o_fwd_write   (o_fwd_write)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic t_bus_res decode_access(input t_mode m, input logic [15:0] a,
                                               input logic [7:0] d, input logic [1:0] p);
        t_bus_res r;
        int       sel;
        r = '0;
        r.target = TGT_NONE;
        case (m)
            MODE_READ: begin
                if (a < ADDR_PICTURE) begin
                    r.target    = TGT_INTERNAL;
                    r.read_data = work_mem[a % RAM_BYTES_DEF];
                end else if (a < ADDR_IO) begin
                    r.target      = TGT_PICTURE;
                    r.fwd_address = a;
                end else if (a == ADDR_APU_ST) begin
                    r.target      = TGT_AUDIO;
                    r.fwd_address = a;
                end else if (a == ADDR_PAD0 || a == ADDR_PAD1) begin
                    sel            = (a == ADDR_PAD1) ? 1 : 0;
                    r.target       = TGT_INTERNAL;
                    r.read_data    = PAD_OPEN_BUS | {7'd0, btn_shreg[sel][0]};
                    btn_shreg[sel] = btn_shreg[sel] >> 1;
                end else if (a < ADDR_CART) begin
                    r.target = TGT_INTERNAL;
                end else begin
                    r.target      = TGT_CART;
                    r.fwd_address = a;
                end
            end
            MODE_WRITE: begin
                if (a < ADDR_PICTURE) begin
                    work_mem[a % RAM_BYTES_DEF] = d;
                    r.target = TGT_INTERNAL;
                end else if (a == ADDR_PAD0) begin
                    if (d[0]) begin
                        strobe_on = 1'b1;
                    end else if (strobe_on) begin
                        strobe_on    = 1'b0;
                        btn_shreg[0] = btn_latch[0];
                        btn_shreg[1] = btn_latch[1];
                    end
                    r.target = TGT_INTERNAL;
                end else if (a < ADDR_IO_END || a >= ADDR_CART) begin
                    if (a < ADDR_IO)
                        r.target = TGT_PICTURE;
                    else if (a == ADDR_DMA)
                        r.target = TGT_DMA;
                    else if (a < ADDR_IO_END)
                        r.target = TGT_AUDIO;
                    else
                        r.target = TGT_CART;
                    r.fwd_address = a;
                    r.fwd_data    = d;
                    r.fwd_write   = 1'b1;
                end
            end
            MODE_PAD: begin
                if (p < 2) begin
                    btn_latch[p[0]] = d;
                    if (strobe_on)
                        btn_shreg[p[0]] = d;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic send_word(input t_mode m, input logic [15:0] a, input logic [7:0] d,
                             input logic [1:0] p, input bit typed, input t_bus_res typed_res);
        t_bus_res r;
        while (!no_gaps && $urandom_range(0, 99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        r = decode_access(m, a, d, p);
        pending_res.push_back(typed ? typed_res : r);
        if (!(m == MODE_NONE || (m == MODE_PAD && p > 1) ||
              (m == MODE_WRITE && a >= ADDR_IO_END && a < ADDR_CART)))
            words_sent++;
        i_valid   <= 1'b1;
        i_mode    <= m;
        i_address <= a;
        i_data_in <= d;
        i_pad     <= p;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic wait_all_results();
        i_valid <= 1'b0;
        while (pending_res.size() != 0) @(posedge i_clk);
    endtask

    // result side: in-order compare and random stall
    initial begin
        t_bus_res want;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                if (pending_res.size() == 0) begin
                    $error("result word with nothing pending: target %0d", o_target);
                    err_cnt++;
                end else begin
                    want = pending_res.pop_front();
                    if (o_target !== want.target) begin
                        $error("target: expected %0d, got %0d", want.target, o_target);
                        err_cnt++;
                    end
                    if (o_read_data !== want.read_data) begin
                        $error("read_data: expected %h, got %h", want.read_data, o_read_data);
                        err_cnt++;
                    end
                    if (o_fwd_address !== want.fwd_address) begin
                        $error("fwd_address: expected %h, got %h",
                               want.fwd_address, o_fwd_address);
                        err_cnt++;
                    end
                    if (o_fwd_data !== want.fwd_data) begin
                        $error("fwd_data: expected %h, got %h", want.fwd_data, o_fwd_data);
                        err_cnt++;
                    end
                    if (o_fwd_write !== want.fwd_write) begin
                        $error("fwd_write: expected %b, got %b", want.fwd_write, o_fwd_write);
                        err_cnt++;
                    end
                end
            end
            i_stall <= (!no_gaps && $urandom_range(0, 99) < IDLE_PCT);
        end
    end

    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        int          kind;
        int          n;
        logic [15:0] a;
        t_mode       m;

        i_rst_n   <= 1'b0;
        i_valid   <= 1'b0;
        i_mode    <= MODE_READ;
        i_address <= '0;
        i_data_in <= '0;
        i_pad     <= '0;
        err_cnt    = 0;
        words_sent = 0;
        no_gaps    = 1'b0;
        strobe_on  = 1'b0;
        foreach (work_mem[k]) work_mem[k] = '0;
        foreach (btn_latch[k]) begin
            btn_latch[k] = '0;
            btn_shreg[k] = '0;
        end

        dir_rows[0]  = {MODE_READ, 16'h0000, 8'h00, 2'd0, 1'b1,
                        TGT_INTERNAL, 8'h00, 16'h0000, 8'h00, 1'b0};
        dir_rows[1]  = {MODE_READ, ADDR_PAD0, 8'h00, 2'd0, 1'b1,
                        TGT_INTERNAL, PAD_OPEN_BUS, 16'h0000, 8'h00, 1'b0};
        dir_rows[2]  = {MODE_WRITE, 16'h07FF, 8'hFF, 2'd0, 1'b1,
                        TGT_INTERNAL, 8'h00, 16'h0000, 8'h00, 1'b0};
        dir_rows[3]  = {MODE_READ, 16'h1FFF, 8'h00, 2'd3, 1'b0, NO_RES};
        dir_rows[4]  = {MODE_READ, ADDR_PICTURE, 8'hFF, 2'd0, 1'b1,
                        TGT_PICTURE, 8'h00, ADDR_PICTURE, 8'h00, 1'b0};
        dir_rows[5]  = {MODE_WRITE, 16'h3FFF, 8'hA5, 2'd0, 1'b1,
                        TGT_PICTURE, 8'h00, 16'h3FFF, 8'hA5, 1'b1};
        dir_rows[6]  = {MODE_READ, ADDR_APU_ST, 8'h00, 2'd0, 1'b1,
                        TGT_AUDIO, 8'h00, ADDR_APU_ST, 8'h00, 1'b0};
        dir_rows[7]  = {MODE_WRITE, ADDR_IO, 8'h01, 2'd0, 1'b1,
                        TGT_AUDIO, 8'h00, ADDR_IO, 8'h01, 1'b1};
        dir_rows[8]  = {MODE_WRITE, ADDR_PAD1, 8'h80, 2'd0, 1'b1,
                        TGT_AUDIO, 8'h00, ADDR_PAD1, 8'h80, 1'b1};
        dir_rows[9]  = {MODE_WRITE, ADDR_DMA, 8'h02, 2'd0, 1'b1,
                        TGT_DMA, 8'h00, ADDR_DMA, 8'h02, 1'b1};
        dir_rows[10] = {MODE_READ, ADDR_IO, 8'h00, 2'd0, 1'b1,
                        TGT_INTERNAL, 8'h00, 16'h0000, 8'h00, 1'b0};
        dir_rows[11] = {MODE_READ, 16'h401F, 8'h00, 2'd0, 1'b1,
                        TGT_INTERNAL, 8'h00, 16'h0000, 8'h00, 1'b0};
        dir_rows[12] = {MODE_WRITE, ADDR_IO_END, 8'h55, 2'd0, 1'b1,
                        TGT_NONE, 8'h00, 16'h0000, 8'h00, 1'b0};
        dir_rows[13] = {MODE_WRITE, 16'h401F, 8'hFF, 2'd0, 1'b1,
                        TGT_NONE, 8'h00, 16'h0000, 8'h00, 1'b0};
        dir_rows[14] = {MODE_READ, ADDR_CART, 8'h00, 2'd0, 1'b1,
                        TGT_CART, 8'h00, ADDR_CART, 8'h00, 1'b0};
        dir_rows[15] = {MODE_WRITE, 16'hFFFF, 8'hFF, 2'd0, 1'b1,
                        TGT_CART, 8'h00, 16'hFFFF, 8'hFF, 1'b1};
        dir_rows[16] = {MODE_PAD, 16'h0000, 8'hA5, 2'd0, 1'b1,
                        TGT_NONE, 8'h00, 16'h0000, 8'h00, 1'b0};
        dir_rows[17] = {MODE_PAD, 16'h0000, 8'h5A, 2'd1, 1'b1,
                        TGT_NONE, 8'h00, 16'h0000, 8'h00, 1'b0};
        dir_rows[18] = {MODE_PAD, 16'hFFFF, 8'hFF, 2'd2, 1'b1,
                        TGT_NONE, 8'h00, 16'h0000, 8'h00, 1'b0};
        dir_rows[19] = {MODE_NONE, 16'hFFFF, 8'hFF, 2'd3, 1'b1,
                        TGT_NONE, 8'h00, 16'h0000, 8'h00, 1'b0};
        dir_rows[20] = {MODE_WRITE, ADDR_PAD0, 8'h01, 2'd0, 1'b1,
                        TGT_INTERNAL, 8'h00, 16'h0000, 8'h00, 1'b0};
        dir_rows[21] = {MODE_PAD, 16'h0000, 8'h3C, 2'd0, 1'b1,
                        TGT_NONE, 8'h00, 16'h0000, 8'h00, 1'b0};
        dir_rows[22] = {MODE_WRITE, ADDR_PAD0, 8'hFE, 2'd0, 1'b1,
                        TGT_INTERNAL, 8'h00, 16'h0000, 8'h00, 1'b0};
        dir_rows[23] = {MODE_READ, ADDR_PAD0, 8'h00, 2'd0, 1'b0, NO_RES};
        dir_rows[24] = {MODE_READ, ADDR_PAD1, 8'h00, 2'd0, 1'b0, NO_RES};

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[k])
            send_word(dir_rows[k].mode, dir_rows[k].addr, dir_rows[k].data,
                      dir_rows[k].pad, dir_rows[k].typed, dir_rows[k].res);
        wait_all_results();

        words_sent = 0;
        while (words_sent < RAND_WORDS) begin
            no_gaps = (words_sent >= 700 && words_sent < 1000);
            kind    = $urandom_range(0, 9);
            case (kind)
                0, 1: begin
                    // narrow address set so reads land on written bytes and mirrors
                    a = 16'($urandom_range(0, 16'h1FFF));
                    if ($urandom_range(0, 1))
                        a[10:0] = 11'($urandom_range(0, 15));
                    m = $urandom_range(0, 1) ? MODE_WRITE : MODE_READ;
                    send_word(m, a, 8'($urandom), 2'($urandom), 1'b0, NO_RES);
                end
                2, 3, 4: begin
                    // strobe high, button updates, release, then serial reads
                    send_word(MODE_WRITE, ADDR_PAD0, 8'($urandom) | 8'h01, 2'($urandom),
                              1'b0, NO_RES);
                    n = $urandom_range(0, 3);
                    repeat (n)
                        send_word(MODE_PAD, 16'($urandom), 8'($urandom), 2'($urandom),
                                  1'b0, NO_RES);
                    send_word(MODE_WRITE, ADDR_PAD0, 8'($urandom) & 8'hFE, 2'($urandom),
                              1'b0, NO_RES);
                    n = $urandom_range(1, 10);
                    repeat (n)
                        send_word(MODE_READ, $urandom_range(0, 1) ? ADDR_PAD1 : ADDR_PAD0,
                                  8'($urandom), 2'($urandom), 1'b0, NO_RES);
                end
                5: send_word(MODE_PAD, 16'($urandom), 8'($urandom), 2'($urandom),
                             1'b0, NO_RES);
                6: begin
                    m = $urandom_range(0, 7) == 0 ? MODE_NONE :
                        ($urandom_range(0, 1) ? MODE_WRITE : MODE_READ);
                    send_word(m, ADDR_IO + 16'($urandom_range(0, 31)), 8'($urandom),
                              2'($urandom), 1'b0, NO_RES);
                end
                7: begin
                    m = $urandom_range(0, 1) ? MODE_WRITE : MODE_READ;
                    a = $urandom_range(0, 1) ? 16'($urandom_range(16'h2000, 16'h3FFF))
                                             : 16'($urandom_range(16'h4020, 16'hFFFF));
                    send_word(m, a, 8'($urandom), 2'($urandom), 1'b0, NO_RES);
                end
                default: send_word(t_mode'($urandom_range(0, 3)), 16'($urandom),
                                   8'($urandom), 2'($urandom), 1'b0, NO_RES);
            endcase
            if ($urandom_range(0, 199) == 0)
                wait_all_results();
        end
        no_gaps = 1'b0;

        wait_all_results();
        repeat (8) @(posedge i_clk);
        if (err_cnt == 0 && pending_res.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
